FILE: hdl/ckl_pkg.sv
// Shared types and constants for the compacting key list core.
// Used by every module of the block; has no dependencies.
package ckl_pkg;

    // List geometry, fixed by the port widths
    localparam int CAPACITY  = 32;
    localparam int KEY_BYTES = 10;
    localparam int RAW_BYTES = 10;
    localparam int KEY_W     = 8 * RAW_BYTES;
    localparam int KEY_LO_W  = 64;
    localparam int KEY_HI_W  = KEY_W - KEY_LO_W;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LEN_W     = $clog2(RAW_BYTES + 1);
    localparam int FUNC_W    = 2;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_READ   = 2'd2
    } t_func;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_RESP
    } t_state;

    // Memory write request
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } t_mem_wr;

    // Finished result handed to the output register
    typedef struct packed {
        logic             ok;
        logic [KEY_W-1:0] data;
        logic [CNT_W-1:0] count;
    } t_result;

endpackage

FILE: hdl/ckl_key_norm.sv
// Key normalizer: clears bytes after the first zero byte and checks the length.
// Depends on ckl_pkg.
module ckl_key_norm (
    input  logic [ckl_pkg::KEY_LO_W-1:0] i_key_low,
    input  logic [ckl_pkg::KEY_HI_W-1:0] i_key_high,
    output logic [ckl_pkg::KEY_W-1:0]    o_key,
    output logic                         o_len_ok
);

    logic [ckl_pkg::KEY_W-1:0] w_raw;
    logic [ckl_pkg::LEN_W-1:0] w_len;

    assign w_raw = {i_key_high, i_key_low};

    // Keep bytes up to the terminator, count them
    always_comb begin
        logic       ended;
        logic [7:0] kbyte;
        ended = 1'b0;
        w_len = '0;
        o_key = '0;
        for (int b = 0; b < ckl_pkg::RAW_BYTES; b++) begin
            kbyte = w_raw[8*b +: 8];
            if (kbyte == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                w_len = w_len + 1'b1;
                o_key[8*b +: 8] = kbyte;
            end
        end
        o_len_ok = (int'(w_len) <= ckl_pkg::KEY_BYTES);
    end

endmodule

FILE: hdl/ckl_mem.sv
// Entry store: one write port, one read port with registered read data.
// Depends on ckl_pkg.
module ckl_mem (
    input  logic                         i_clk,
    input  ckl_pkg::t_mem_wr             i_wr,
    input  logic [ckl_pkg::IDX_W-1:0]    i_raddr,
    output logic [ckl_pkg::KEY_W-1:0]    o_rdata
);

    logic [ckl_pkg::KEY_W-1:0] r_mem [ckl_pkg::CAPACITY];
    logic [ckl_pkg::KEY_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ckl_ctrl.sv
// Operation sequencer: append, read, and remove as a streaming scan that
// compares each entry and moves later entries down one place.
// Depends on ckl_pkg; drives ckl_mem.
module ckl_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ckl_pkg::FUNC_W-1:0]    i_func,
    input  logic [ckl_pkg::IDX_W-1:0]     i_position,
    input  logic [ckl_pkg::KEY_W-1:0]     i_key,
    input  logic                          i_len_ok,
    output ckl_pkg::t_mem_wr              o_wr,
    output logic [ckl_pkg::IDX_W-1:0]     o_raddr,
    input  logic [ckl_pkg::KEY_W-1:0]     i_rdata,
    output logic                          o_res_valid,
    output ckl_pkg::t_result              o_res,
    input  logic                          i_res_take
);

    ckl_pkg::t_state             r_state, n_state;
    logic [ckl_pkg::CNT_W-1:0]   r_count, n_count;
    logic [ckl_pkg::KEY_W-1:0]   r_key,   n_key;
    logic [ckl_pkg::CNT_W-1:0]   r_rd_idx, n_rd_idx;
    logic [ckl_pkg::IDX_W-1:0]   r_cmp_idx, n_cmp_idx;
    logic                        r_found, n_found;
    logic                        r_ok,    n_ok;
    logic [ckl_pkg::KEY_W-1:0]   r_data,  n_data;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ckl_pkg::ST_IDLE;
            r_count <= '0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_found <= n_found;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_ok      <= n_ok;
        r_data    <= n_data;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_key     = r_key;
        n_rd_idx  = r_rd_idx;
        n_cmp_idx = r_cmp_idx;
        n_found   = r_found;
        n_ok      = r_ok;
        n_data    = r_data;
        o_wr      = '0;
        o_raddr   = '0;
        o_ready   = 1'b0;

        case (r_state)
            ckl_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_key   = i_key;
                    n_ok    = 1'b0;
                    n_data  = '0;
                    n_found = 1'b0;
                    n_state = ckl_pkg::ST_RESP;
                    case (i_func)
                        ckl_pkg::FUNC_APPEND: begin
                            if (r_count < ckl_pkg::CNT_W'(ckl_pkg::CAPACITY) && i_len_ok) begin
                                o_wr.we   = 1'b1;
                                o_wr.addr = r_count[ckl_pkg::IDX_W-1:0];
                                o_wr.data = i_key;
                                n_count   = r_count + 1'b1;
                                n_ok      = 1'b1;
                            end
                        end
                        ckl_pkg::FUNC_REMOVE: begin
                            // start the scan at entry zero
                            if (r_count != '0 && i_len_ok) begin
                                o_raddr   = '0;
                                n_cmp_idx = '0;
                                n_rd_idx  = ckl_pkg::CNT_W'(1);
                                n_state   = ckl_pkg::ST_SCAN;
                            end
                        end
                        ckl_pkg::FUNC_READ: begin
                            if ({1'b0, i_position} < r_count) begin
                                o_raddr = i_position;
                                n_state = ckl_pkg::ST_READ;
                            end
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            ckl_pkg::ST_READ: begin
                n_ok    = 1'b1;
                n_data  = i_rdata;
                n_state = ckl_pkg::ST_RESP;
            end
            ckl_pkg::ST_SCAN: begin
                // data of entry r_cmp_idx is on the read port now
                if (r_found) begin
                    o_wr.we   = 1'b1;
                    o_wr.addr = r_cmp_idx - 1'b1;
                    o_wr.data = i_rdata;
                end else if (i_rdata == r_key) begin
                    n_found = 1'b1;
                end
                if (r_rd_idx < r_count) begin
                    o_raddr   = r_rd_idx[ckl_pkg::IDX_W-1:0];
                    n_cmp_idx = r_rd_idx[ckl_pkg::IDX_W-1:0];
                    n_rd_idx  = r_rd_idx + 1'b1;
                end else begin
                    n_ok    = n_found;
                    n_data  = '0;
                    if (n_found) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = ckl_pkg::ST_RESP;
                end
            end
            ckl_pkg::ST_RESP: begin
                if (i_res_take) begin
                    n_state = ckl_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ckl_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_valid = (r_state == ckl_pkg::ST_RESP);
    assign o_res.ok    = r_ok;
    assign o_res.data  = r_data;
    assign o_res.count = r_count;

endmodule

FILE: hdl/compacting_key_list_core.sv
// Compacting key list core: ordered list of 80-bit keys in a 32-entry memory.
// Append, rejected operations: idle, then response. Read: idle, read, response.
// Remove: one read/write per entry scanned; no new item until the result leaves.
// The single read port of the entry memory sets the remove time.
// Reset (synchronous, active low) empties the list; entry contents stay undefined.
module compacting_key_list_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ckl_pkg::FUNC_W-1:0]      i_func,
    input  logic [ckl_pkg::KEY_LO_W-1:0]    i_key_low,
    input  logic [ckl_pkg::KEY_HI_W-1:0]    i_key_high,
    input  logic [ckl_pkg::IDX_W-1:0]       i_position,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_ok,
    output logic [ckl_pkg::KEY_LO_W-1:0]    o_data_low,
    output logic [ckl_pkg::KEY_HI_W-1:0]    o_data_high,
    output logic [ckl_pkg::CNT_W-1:0]       o_entry_count,
    output logic                            o_is_empty,
    output logic                            o_is_full
);

    logic [ckl_pkg::KEY_W-1:0]  w_key;
    logic                       w_len_ok;
    ckl_pkg::t_mem_wr           w_wr;
    logic [ckl_pkg::IDX_W-1:0]  w_raddr;
    logic [ckl_pkg::KEY_W-1:0]  w_rdata;
    logic                       w_res_valid;
    ckl_pkg::t_result           w_res;
    logic                       w_out_free;

    logic                       r_out_valid;
    logic                       r_ok;
    logic [ckl_pkg::KEY_W-1:0]  r_data;
    logic [ckl_pkg::CNT_W-1:0]  r_count;

    ckl_key_norm u_norm (
        .i_key_low  (i_key_low),
        .i_key_high (i_key_high),
        .o_key      (w_key),
        .o_len_ok   (w_len_ok)
    );

    ckl_mem u_mem (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ckl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_func      (i_func),
        .i_position  (i_position),
        .i_key       (w_key),
        .i_len_ok    (w_len_ok),
        .o_wr        (w_wr),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_out_free)
    );

    // Output register, free when empty or being drained
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_res_valid) begin
            r_ok    <= w_res.ok;
            r_data  <= w_res.data;
            r_count <= w_res.count;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_data_low    = r_data[ckl_pkg::KEY_LO_W-1:0];
    assign o_data_high   = r_data[ckl_pkg::KEY_W-1:ckl_pkg::KEY_LO_W];
    assign o_entry_count = r_count;
    assign o_is_empty    = (r_count == '0);
    assign o_is_full     = (r_count == ckl_pkg::CNT_W'(ckl_pkg::CAPACITY));

    // Live count never exceeds the memory depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.count <= ckl_pkg::CNT_W'(ckl_pkg::CAPACITY))
        else $error("live count above capacity");

    // No new item is taken while a result waits in the sequencer
    a_ready_vs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && w_res_valid))
        else $error("ready while result pending");

    // Data fields are zero unless the operation succeeded
    a_fail_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_data_low == '0 && o_data_high == '0))
        else $error("nonzero data on failed item");

endmodule
